// File: rtl/svoe_pkg.sv
// Package for the synthesizer voice: widths, register codes, the rate and sustain tables,
// the sequencer and envelope stage types and the shared multiplier request.
// No dependencies.
package svoe_pkg;

   localparam int unsigned SAMPLE_RATE_DEF = 44100;

   localparam int SCALE_W  = 24;
   localparam int FREQ_W   = 16;
   localparam int PHASE_W  = 24;
   localparam int ENV_W    = 17;
   localparam int LFSR_W   = 23;
   localparam int WAVE_W   = 12;
   localparam int LEVEL_W  = 8;
   localparam int SAMPLE_W = 16;
   localparam int MOVE_W   = 19;
   localparam int COEF_W   = 34;
   localparam int MUL_A_W  = 17;
   localparam int MUL_B_W  = 34;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int NUM_REGS = 7;

   localparam logic [SCALE_W-1:0] PHASE_SCALE_RST = 24'd1464145;
   localparam logic [LFSR_W-1:0]  LFSR_SEED       = 23'h7FFFF8;
   localparam logic [ENV_W-1:0]   ENV_FULL        = 17'd65536;
   localparam logic [ENV_W-1:0]   DECAY_SNAP      = 17'd66;
   localparam logic [ENV_W-1:0]   RELEASE_SNAP    = 17'd33;
   localparam logic [WAVE_W-1:0]  WAVE_MID        = 12'd2048;
   localparam logic [WAVE_W-1:0]  WAVE_MAX        = 12'd4095;
   localparam logic [35:0]        TRI_FULL        = 36'hFFF000000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'd255;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [2:0] REG_FREQ_LO = 3'd0;
   localparam logic [2:0] REG_FREQ_HI = 3'd1;
   localparam logic [2:0] REG_PW_LO   = 3'd2;
   localparam logic [2:0] REG_PW_HI   = 3'd3;
   localparam logic [2:0] REG_CTRL    = 3'd4;
   localparam logic [2:0] REG_AD      = 3'd5;
   localparam logic [2:0] REG_SR      = 3'd6;

   localparam int CTRL_GATE  = 0;
   localparam int CTRL_TEST  = 3;
   localparam int CTRL_TRI   = 4;
   localparam int CTRL_SAW   = 5;
   localparam int CTRL_PULSE = 6;
   localparam int CTRL_NOISE = 7;

   // Envelope times in milliseconds, one per rate nibble.
   localparam logic [13:0] RATE_MS [16] = '{
      14'd2,   14'd8,   14'd16,   14'd24,   14'd38,   14'd56,   14'd68,   14'd80,
      14'd100, 14'd250, 14'd500,  14'd800,  14'd1000, 14'd3000, 14'd5000, 14'd8000};

   // Sustain nibble times full scale over fifteen, rounded down.
   localparam logic [ENV_W-1:0] SUSTAIN_TAB [16] = '{
      17'd0,     17'd4369,  17'd8738,  17'd13107, 17'd17476, 17'd21845, 17'd26214, 17'd30583,
      17'd34952, 17'd39321, 17'd43690, 17'd48059, 17'd52428, 17'd56797, 17'd61166, 17'd65536};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENV,
      ST_ENV_UPD,
      ST_OSC,
      ST_RAMP,
      ST_WAVE,
      ST_VS,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      ENV_IDLE    = 2'd0,
      ENV_ATTACK  = 2'd1,
      ENV_DECAY   = 2'd2,
      ENV_RELEASE = 2'd3
   } env_stage_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   // Eight taps of the noise register, placed in the top byte of a 12-bit level.
   function automatic logic [WAVE_W-1:0] lfsr_tap_level(input logic [LFSR_W-1:0] l);
      return {l[22], l[20], l[16], l[13], l[11], l[7], l[4], l[2], 4'b0000};
   endfunction

endpackage

// File: rtl/svoe_mul.sv
// Shared multiplier of the voice: one registered unsigned product per enabled cycle.
// Depends on svoe_pkg for the operand widths and the request struct.
module svoe_mul import svoe_pkg::*; (
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = mul_req.a * mul_req.b;

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// File: rtl/synth_voice_oscillator_envelope_unit.sv
// One synthesizer voice: register writes, ADSR envelope and phase-accumulator oscillator.
// A register write is taken while the voice is idle; a tick walks seven sequencer
// steps through the one shared multiplier and its result is registered in the last step.
// No tick is taken before the last one is done; a stalled result holds the last step.
// Synchronous reset clears voice registers, envelope, oscillator and handshake; it sets
// the phase scale and noise register to default and seed. Depends on svoe_pkg, svoe_mul.
module synth_voice_oscillator_envelope_unit import svoe_pkg::*; #(
   parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [2:0]                 req_reg_index,
   input  logic [7:0]                 req_reg_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [WAVE_W-1:0]          rsp_wave_level,
   output logic [LEVEL_W-1:0]         rsp_env_level,
   output logic [LEVEL_W-1:0]         rsp_osc_readback,
   output logic signed [SAMPLE_W-1:0] rsp_voice_sample,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SCALE_W-1:0]         csr_phase_scale
);

   // Per-sample attack steps and Q32 decay and release coefficients, fixed at elaboration.
   logic [ENV_W-1:0]  atk_tab  [16];
   logic [COEF_W-1:0] coef_tab [16];

   for (genvar gi = 0; gi < 16; gi++) begin : g_rate
      localparam logic [63:0] NA   = 64'(RATE_MS[gi]) * 64'(SAMPLE_RATE);
      localparam logic [63:0] ND   = 64'd3 * NA;
      localparam logic [63:0] QA   = 64'd65536000 / ((NA == 64'd0) ? 64'd1 : NA);
      localparam logic [63:0] STEP = (NA <= 64'd1000) ? 64'd65536 :
                                     ((QA == 64'd0) ? 64'd1 : QA);
      localparam logic [63:0] COEF = (ND <= 64'd1000) ? (64'd2 << 32) :
                                     ((64'd1000 << 33) / ND);
      assign atk_tab[gi]  = ENV_W'(STEP);
      assign coef_tab[gi] = COEF_W'(COEF);
   end

   state_type           state_ff, state_in;
   env_stage_type       env_stage_ff, env_stage_in;
   logic                gate_prev_ff, gate_prev_in;
   logic [ENV_W-1:0]    env_ff, env_in;
   logic [PHASE_W-1:0]  osc_ff, osc_in;
   logic [PHASE_W-1:0]  noise_phase_ff, noise_phase_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [WAVE_W-1:0]   hold_ff, hold_in;
   logic [WAVE_W-1:0]   wave_ff, wave_in;
   logic [SCALE_W-1:0]  scale_ff;
   logic [7:0]          voice_ff [NUM_REGS];
   logic                voice_we;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WAVE_W-1:0]       rsp_wave_ff, rsp_wave_in;
   logic [LEVEL_W-1:0]      rsp_env_ff, rsp_env_in;
   logic [LEVEL_W-1:0]      rsp_osc_ff, rsp_osc_in;
   logic [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;

   mul_req_type        mul_req;
   logic [PROD_W-1:0]  prod_ff;

   svoe_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   logic [7:0]         ctrl, ad, sr;
   logic [ENV_W-1:0]   sus;
   logic               env_ge_sus;
   logic [ENV_W-1:0]   env_dist;

   assign ctrl       = voice_ff[REG_CTRL];
   assign ad         = voice_ff[REG_AD];
   assign sr         = voice_ff[REG_SR];
   assign sus        = SUSTAIN_TAB[sr[7:4]];
   assign env_ge_sus = (env_ff >= sus);
   assign env_dist   = env_ge_sus ? (env_ff - sus) : (sus - env_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign voice_we  = req_valid && req_ready && (req_op == OP_WRITE) &&
                      (req_reg_index <= REG_SR);

   always_comb begin
      logic                gate;
      env_stage_type       stage_eff;
      logic [ENV_W-1:0]    move_d;
      logic [MOVE_W-1:0]   move;
      logic [ENV_W:0]      atk_sum;
      logic [MOVE_W:0]     e2;
      logic [MOVE_W:0]     d2;
      logic [PHASE_W-1:0]  inc;
      logic [PHASE_W:0]    nsum;
      logic [LFSR_W-1:0]   lfsr_next;
      logic [35:0]         ramp;
      logic [35:0]         tri_x;
      logic [WAVE_W-1:0]   acc;
      logic                any;
      logic [WAVE_W-1:0]   mag;
      logic signed [29:0]  sprod;
      logic [24:0]         lvl;

      state_in       = state_ff;
      env_stage_in   = env_stage_ff;
      gate_prev_in   = gate_prev_ff;
      env_in         = env_ff;
      osc_in         = osc_ff;
      noise_phase_in = noise_phase_ff;
      lfsr_in        = lfsr_ff;
      hold_in        = hold_ff;
      wave_in        = wave_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_wave_in    = rsp_wave_ff;
      rsp_env_in     = rsp_env_ff;
      rsp_osc_in     = rsp_osc_ff;
      rsp_sample_in  = rsp_sample_ff;
      mul_req        = '0;

      gate      = ctrl[CTRL_GATE];
      stage_eff = env_stage_ff;
      if (gate && !gate_prev_ff) begin
         stage_eff = ENV_ATTACK;
      end else if (!gate && gate_prev_ff) begin
         stage_eff = ENV_RELEASE;
      end

      move_d = (env_stage_ff == ENV_DECAY) ? env_dist : env_ff;
      move   = prod_ff[32 +: MOVE_W];
      if (move == '0 && move_d != '0) begin
         move = MOVE_W'(1);
      end

      atk_sum   = {1'b0, env_ff} + {1'b0, atk_tab[ad[7:4]]};
      e2        = '0;
      d2        = '0;
      inc       = prod_ff[16 +: PHASE_W];
      nsum      = {1'b0, noise_phase_ff} + {1'b0, inc};
      lfsr_next = {lfsr_ff[LFSR_W-2:0], lfsr_ff[22] ^ lfsr_ff[17]};
      ramp      = prod_ff[35:0];
      tri_x     = osc_ff[PHASE_W-1] ? (TRI_FULL - ramp) : ramp;
      acc       = WAVE_MAX;
      any       = 1'b0;
      mag       = (wave_ff >= WAVE_MID) ? (wave_ff - WAVE_MID) : (WAVE_MID - wave_ff);
      sprod     = (wave_ff < WAVE_MID) ? -$signed({1'b0, prod_ff[28:0]})
                                       : $signed({1'b0, prod_ff[28:0]});
      lvl       = {env_ff, 8'b0} - {8'b0, env_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op == OP_TICK) begin
               state_in = ST_ENV;
            end
         end
         ST_ENV: begin
            env_stage_in = stage_eff;
            gate_prev_in = gate;
            mul_req.en   = 1'b1;
            if (stage_eff == ENV_DECAY) begin
               mul_req.a = env_dist;
               mul_req.b = coef_tab[ad[3:0]];
            end else if (stage_eff == ENV_RELEASE) begin
               mul_req.a = env_ff;
               mul_req.b = coef_tab[sr[3:0]];
            end
            state_in = ST_ENV_UPD;
         end
         ST_ENV_UPD: begin
            case (env_stage_ff)
               ENV_ATTACK: begin
                  if (atk_sum >= {1'b0, ENV_FULL}) begin
                     env_in       = ENV_FULL;
                     env_stage_in = ENV_DECAY;
                  end else begin
                     env_in = atk_sum[ENV_W-1:0];
                  end
               end
               ENV_DECAY: begin
                  if (env_ge_sus) begin
                     e2 = (move > MOVE_W'(env_ff)) ? '0 : ((MOVE_W+1)'(env_ff) - (MOVE_W+1)'(move));
                  end else begin
                     e2 = (MOVE_W+1)'(env_ff) + (MOVE_W+1)'(move);
                  end
                  if (e2 > (MOVE_W+1)'(ENV_FULL)) begin
                     e2 = (MOVE_W+1)'(ENV_FULL);
                  end
                  d2 = (e2 >= (MOVE_W+1)'(sus)) ? (e2 - (MOVE_W+1)'(sus))
                                                : ((MOVE_W+1)'(sus) - e2);
                  env_in = (d2 < (MOVE_W+1)'(DECAY_SNAP)) ? sus : e2[ENV_W-1:0];
               end
               ENV_RELEASE: begin
                  e2 = (move > MOVE_W'(env_ff)) ? '0 : ((MOVE_W+1)'(env_ff) - (MOVE_W+1)'(move));
                  if (e2 < (MOVE_W+1)'(RELEASE_SNAP)) begin
                     env_in       = '0;
                     env_stage_in = ENV_IDLE;
                  end else begin
                     env_in = e2[ENV_W-1:0];
                  end
               end
               default: begin
                  env_in = '0;
               end
            endcase
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'({voice_ff[REG_FREQ_HI], voice_ff[REG_FREQ_LO]});
            mul_req.b  = MUL_B_W'(scale_ff);
            state_in   = ST_OSC;
         end
         ST_OSC: begin
            if (ctrl[CTRL_TEST]) begin
               osc_in = '0;
            end else begin
               osc_in = osc_ff + inc;
               if (ctrl[CTRL_NOISE]) begin
                  // The phase increment is below one full turn, so at most one wrap.
                  noise_phase_in = nsum[PHASE_W-1:0];
                  if (nsum[PHASE_W]) begin
                     lfsr_in = lfsr_next;
                     hold_in = lfsr_tap_level(lfsr_next);
                  end
               end
            end
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(WAVE_MAX);
            mul_req.b  = MUL_B_W'(osc_ff);
            state_in   = ST_WAVE;
         end
         ST_WAVE: begin
            if (ctrl[CTRL_TRI]) begin
               acc = acc & tri_x[34:23];
               any = 1'b1;
            end
            if (ctrl[CTRL_SAW]) begin
               acc = acc & ramp[35:24];
               any = 1'b1;
            end
            if (ctrl[CTRL_PULSE]) begin
               if (osc_ff >= {voice_ff[REG_PW_HI][3:0], voice_ff[REG_PW_LO], 12'h000}) begin
                  acc = '0;
               end
               any = 1'b1;
            end
            if (ctrl[CTRL_NOISE]) begin
               acc = acc & hold_ff;
               any = 1'b1;
            end
            wave_in  = (ctrl[CTRL_TEST] || !any) ? WAVE_MID : acc;
            state_in = ST_VS;
         end
         ST_VS: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(mag);
            mul_req.b  = MUL_B_W'(env_ff);
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_wave_in   = wave_ff;
               rsp_osc_in    = wave_ff[WAVE_W-1:4];
               rsp_env_in    = (lvl[24:16] > 9'(LEVEL_MAX)) ? LEVEL_MAX : lvl[23:16];
               rsp_sample_in = SAMPLE_W'(sprod >>> 12);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         env_stage_ff   <= ENV_IDLE;
         gate_prev_ff   <= 1'b0;
         env_ff         <= '0;
         osc_ff         <= '0;
         noise_phase_ff <= '0;
         lfsr_ff        <= LFSR_SEED;
         hold_ff        <= '0;
         scale_ff       <= PHASE_SCALE_RST;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            voice_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         env_stage_ff   <= env_stage_in;
         gate_prev_ff   <= gate_prev_in;
         env_ff         <= env_in;
         osc_ff         <= osc_in;
         noise_phase_ff <= noise_phase_in;
         lfsr_ff        <= lfsr_in;
         hold_ff        <= hold_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid) begin
            scale_ff <= csr_phase_scale;
         end
         if (voice_we) begin
            voice_ff[req_reg_index] <= req_reg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      wave_ff       <= wave_in;
      rsp_wave_ff   <= rsp_wave_in;
      rsp_env_ff    <= rsp_env_in;
      rsp_osc_ff    <= rsp_osc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wave_level   = rsp_wave_ff;
   assign rsp_env_level    = rsp_env_ff;
   assign rsp_osc_readback = rsp_osc_ff;
   assign rsp_voice_sample = $signed(rsp_sample_ff);

endmodule

// File: rtl/svoe_checker.sv
// Port-level checks for the synthesizer voice, bound to its top level.
// Depends on svoe_pkg and synth_voice_oscillator_envelope_unit.
module svoe_checker import svoe_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_op,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [WAVE_W-1:0]          rsp_wave_level,
   input logic [LEVEL_W-1:0]         rsp_env_level,
   input logic [LEVEL_W-1:0]         rsp_osc_readback,
   input logic signed [SAMPLE_W-1:0] rsp_voice_sample
);

   // A stalled result word keeps its wave, envelope and sample fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wave_level) &&
         $stable(rsp_env_level) && $stable(rsp_voice_sample))
      else $error("result word changed while stalled");

   // A tick keeps the voice busy in the following cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_TICK |=> !req_ready)
      else $error("voice ready straight after a tick");

   // A register write never produces a result word.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result word after a register write");

   a_readback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_osc_readback == rsp_wave_level[WAVE_W-1:4])
      else $error("waveform read-back does not match the level");

   // A centred waveform gives silence whatever the envelope.
   a_mid_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wave_level == WAVE_MID |-> rsp_voice_sample == '0)
      else $error("non-zero sample from a centred waveform");

endmodule

bind synth_voice_oscillator_envelope_unit svoe_checker u_svoe_checker (.*);

// File: dv/voice_tick_checker.sv
`timescale 1ns / 1ps
// Checker for the synthesizer voice: watches the request, result and phase-scale channels,
// predicts each tick's wave, envelope and sample words and compares them in order.
// Depends on svoe_pkg for widths, register codes and the envelope stage type.
module voice_tick_checker import svoe_pkg::*; #(
   parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_op,
   input  logic [2:0]                 req_reg_index,
   input  logic [7:0]                 req_reg_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [WAVE_W-1:0]          rsp_wave_level,
   input  logic [LEVEL_W-1:0]         rsp_env_level,
   input  logic [LEVEL_W-1:0]         rsp_osc_readback,
   input  logic signed [SAMPLE_W-1:0] rsp_voice_sample,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [SCALE_W-1:0]         csr_phase_scale,
   output int                         fail_count,
   output int                         words_due
);

   localparam logic [31:0] FULL_SCALE        = 32'd65536;
   localparam logic [31:0] SUSTAIN_SNAP_BAND = 32'd66;
   localparam logic [31:0] SILENCE_FLOOR     = 32'd33;
   localparam logic [11:0] CENTRE_LEVEL      = 12'd2048;
   localparam logic [22:0] NOISE_START       = 23'h7FFFF8;
   localparam logic [23:0] SCALE_AT_RESET    = 24'd1464145;

   // Envelope segment times in milliseconds, indexed by a rate nibble.
   localparam int unsigned SEGMENT_MS [16] = '{
      2, 8, 16, 24, 38, 56, 68, 80, 100, 250, 500, 800, 1000, 3000, 5000, 8000};

   typedef struct packed {
      logic [11:0] wave;
      logic [7:0]  level;
      logic [7:0]  readback;
      logic [15:0] sample;
   } voice_word_type;

   voice_word_type voice_words_due [$];
   int             errors = 0;

   logic [23:0]   scale_q;
   logic [7:0]    vregs [NUM_REGS];
   logic [23:0]   phase_acc;
   logic [23:0]   noise_acc;
   logic [22:0]   lfsr;
   logic [11:0]   noise_lvl;
   logic [16:0]   env;
   env_stage_type stage;
   logic          gate_d;

   function automatic void clear_voice();
      scale_q   = SCALE_AT_RESET;
      for (int i = 0; i < NUM_REGS; i++) vregs[i] = 8'd0;
      phase_acc = '0;
      noise_acc = '0;
      lfsr      = NOISE_START;
      noise_lvl = '0;
      env       = '0;
      stage     = ENV_IDLE;
      gate_d    = 1'b0;
   endfunction

   function automatic logic [31:0] attack_inc(input logic [3:0] nibble);
      logic [63:0] n;
      n = 64'(SEGMENT_MS[nibble]) * 64'(SAMPLE_RATE);
      if (n <= 64'd1000) return FULL_SCALE;
      n = 64'd65536000 / n;
      return (n == 64'd0) ? 32'd1 : n[31:0];
   endfunction

   // Q32 fraction of the remaining distance covered per sample.
   function automatic logic [63:0] glide_coef(input logic [3:0] nibble);
      logic [63:0] n;
      n = 64'd3 * 64'(SEGMENT_MS[nibble]) * 64'(SAMPLE_RATE);
      if (n <= 64'd1000) return 64'd2 << 32;
      return (64'd1000 << 33) / n;
   endfunction

   // A move that rounds to nothing still moves by one, so slow ramps finish.
   function automatic logic [31:0] glide_step(input logic [31:0] d, input logic [63:0] c);
      logic [63:0] a;
      a = (64'(d) * c) >> 32;
      if (a == 64'd0 && d != 32'd0) a = 64'd1;
      return a[31:0];
   endfunction

   function automatic void step_envelope();
      logic        gate;
      logic [31:0] sus;
      logic [31:0] e;
      logic [31:0] a;
      gate = vregs[REG_CTRL][CTRL_GATE];
      sus  = (32'(vregs[REG_SR][7:4]) * FULL_SCALE) / 32'd15;
      e    = 32'(env);
      if (gate && !gate_d) stage = ENV_ATTACK;
      else if (!gate && gate_d) stage = ENV_RELEASE;
      gate_d = gate;
      case (stage)
         ENV_ATTACK: begin
            e = e + attack_inc(vregs[REG_AD][7:4]);
            if (e >= FULL_SCALE) begin
               e     = FULL_SCALE;
               stage = ENV_DECAY;
            end
         end
         ENV_DECAY: begin
            if (e >= sus) begin
               a = glide_step(e - sus, glide_coef(vregs[REG_AD][3:0]));
               e = (a > e) ? 32'd0 : e - a;
            end else begin
               a = glide_step(sus - e, glide_coef(vregs[REG_AD][3:0]));
               e = e + a;
            end
            if (e > FULL_SCALE) e = FULL_SCALE;
            if (((e >= sus) ? e - sus : sus - e) < SUSTAIN_SNAP_BAND) e = sus;
         end
         ENV_RELEASE: begin
            a = glide_step(e, glide_coef(vregs[REG_SR][3:0]));
            e = (a > e) ? 32'd0 : e - a;
            if (e < SILENCE_FLOOR) begin
               e     = 32'd0;
               stage = ENV_IDLE;
            end
         end
         default: e = 32'd0;
      endcase
      env = e[16:0];
   endfunction

   function automatic logic [11:0] step_oscillator();
      logic [7:0]  ctrl;
      logic [63:0] inc;
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] wraps;
      logic [23:0] p;
      logic [31:0] pw;
      logic [11:0] acc;
      logic        any;
      logic        fb;
      ctrl = vregs[REG_CTRL];
      inc  = (64'({vregs[REG_FREQ_HI], vregs[REG_FREQ_LO]}) * 64'(scale_q)) >> 16;
      acc  = 12'hFFF;
      any  = 1'b0;
      if (ctrl[CTRL_TEST]) begin
         phase_acc = '0;
         return CENTRE_LEVEL;
      end
      phase_acc = phase_acc + inc[23:0];
      p  = phase_acc;
      pw = {20'd0, vregs[REG_PW_HI][3:0], vregs[REG_PW_LO]};
      if (ctrl[CTRL_TRI]) begin
         t   = (p < 24'h800000) ? 64'(p) * 64'd4095 : (64'h1000000 - 64'(p)) * 64'd4095;
         acc = acc & t[34:23];
         any = 1'b1;
      end
      if (ctrl[CTRL_SAW]) begin
         t   = 64'(p) * 64'd4095;
         acc = acc & t[35:24];
         any = 1'b1;
      end
      if (ctrl[CTRL_PULSE]) begin
         acc = acc & ((32'(p) < (pw << 12)) ? 12'hFFF : 12'h000);
         any = 1'b1;
      end
      if (ctrl[CTRL_NOISE]) begin
         // The shift register steps once for every wrap of its own phase.
         sum       = 64'(noise_acc) + inc;
         wraps     = sum >> 24;
         noise_acc = sum[23:0];
         while (wraps != 64'd0) begin
            fb        = lfsr[22] ^ lfsr[17];
            lfsr      = {lfsr[21:0], fb};
            noise_lvl = {lfsr[22], lfsr[20], lfsr[16], lfsr[13],
                         lfsr[11], lfsr[7], lfsr[4], lfsr[2], 4'b0000};
            wraps     = wraps - 64'd1;
         end
         acc = acc & noise_lvl;
         any = 1'b1;
      end
      return any ? acc : CENTRE_LEVEL;
   endfunction

   function automatic voice_word_type predict_tick();
      voice_word_type w;
      logic [31:0]    lvl;
      int             centred;
      int             prod;
      step_envelope();
      w.wave     = step_oscillator();
      lvl        = (32'(env) * 32'd255) >> 16;
      if (lvl > 32'd255) lvl = 32'd255;
      w.level    = lvl[7:0];
      w.readback = w.wave[11:4];
      centred    = int'(w.wave) - 2048;
      prod       = centred * int'(env);
      w.sample   = 16'(prod >>> 12);
      return w;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      voice_word_type due;
      if (reset) begin
         clear_voice();
         voice_words_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (voice_words_due.size() == 0) begin
               $error("result word arrived with no tick outstanding");
               errors++;
            end else begin
               due = voice_words_due.pop_front();
               check_field("wave_level", due.wave, rsp_wave_level);
               check_field("env_level", due.level, rsp_env_level);
               check_field("osc_readback", due.readback, rsp_osc_readback);
               check_field("voice_sample", $signed(due.sample), rsp_voice_sample);
            end
         end
         if (csr_valid && csr_ready) scale_q = csr_phase_scale;
         if (req_valid && req_ready) begin
            if (req_op == OP_TICK) voice_words_due.push_back(predict_tick());
            else if (req_reg_index < NUM_REGS) vregs[req_reg_index] = req_reg_data;
         end
      end
      fail_count <= errors;
      words_due  <= voice_words_due.size();
   end

endmodule

// File: dv/tb_synth_voice_oscillator_envelope_unit.sv
`timescale 1ns / 1ps
// Top of the synthesizer voice testbench: clock, reset, stimulus, result back-pressure,
// watchdog and verdict. Depends on svoe_pkg, the voice unit and voice_tick_checker.
module tb_synth_voice_oscillator_envelope_unit;
   import svoe_pkg::*;

   localparam logic [2:0] REG_NONE      = 3'd7;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         TAIL_CYCLES   = 24;
   localparam int         STALL_LIMIT   = 2000;

   logic                       clock;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic                       req_op          = OP_WRITE;
   logic [2:0]                 req_reg_index   = REG_FREQ_LO;
   logic [7:0]                 req_reg_data    = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [WAVE_W-1:0]          rsp_wave_level;
   logic [LEVEL_W-1:0]         rsp_env_level;
   logic [LEVEL_W-1:0]         rsp_osc_readback;
   logic signed [SAMPLE_W-1:0] rsp_voice_sample;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [SCALE_W-1:0]         csr_phase_scale = '0;

   int   fail_count;
   int   words_due;
   int   items_sent = 0;
   logic idle_on    = 1'b1;

   synth_voice_oscillator_envelope_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_index    (req_reg_index),
      .req_reg_data     (req_reg_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wave_level   (rsp_wave_level),
      .rsp_env_level    (rsp_env_level),
      .rsp_osc_readback (rsp_osc_readback),
      .rsp_voice_sample (rsp_voice_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_phase_scale  (csr_phase_scale)
   );

   voice_tick_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_index    (req_reg_index),
      .req_reg_data     (req_reg_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wave_level   (rsp_wave_level),
      .rsp_env_level    (rsp_env_level),
      .rsp_osc_readback (rsp_osc_readback),
      .rsp_voice_sample (rsp_voice_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_phase_scale  (csr_phase_scale),
      .fail_count       (fail_count),
      .words_due        (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Entered at a clock edge; leaves at the edge where the word is taken, valid still high.
   task automatic send_word(input logic op, input logic [2:0] idx, input logic [7:0] data);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_reg_index <= idx;
      req_reg_data  <= data;
      do @(posedge clock); while (!req_ready);
      if (!(op == OP_WRITE && idx == REG_NONE)) items_sent++;
   endtask

   // Holds off until every tick has been answered, then writes the phase scale.
   task automatic set_scale(input logic [SCALE_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_phase_scale <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Ticks with don't-care fields, now and then broken up by a stray register write.
   task automatic run_ticks(input int n);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0)
            send_word(OP_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         else
            send_word(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
   endtask

   // One note: set up the voice, gate on, hold, gate off, let it ring out.
   task automatic play_note();
      logic       long_note;
      logic [7:0] ctrl;
      logic [7:0] ad;
      long_note = ($urandom_range(0, 5) == 0);
      ad        = 8'($urandom_range(0, 255));
      if (long_note) ad[7:4] = 4'($urandom_range(0, 1));
      send_word(OP_WRITE, REG_FREQ_LO, 8'($urandom_range(0, 255)));
      send_word(OP_WRITE, REG_FREQ_HI, 8'($urandom_range(0, 255)));
      send_word(OP_WRITE, REG_PW_LO, 8'($urandom_range(0, 255)));
      send_word(OP_WRITE, REG_PW_HI, 8'($urandom_range(0, 255)));
      send_word(OP_WRITE, REG_AD, ad);
      send_word(OP_WRITE, REG_SR, 8'($urandom_range(0, 255)));
      ctrl             = 8'($urandom_range(0, 255));
      ctrl[CTRL_GATE]  = 1'b1;
      ctrl[CTRL_TEST]  = ($urandom_range(0, 7) == 0);
      send_word(OP_WRITE, REG_CTRL, ctrl);
      run_ticks(long_note ? $urandom_range(90, 160) : $urandom_range(1, 30));
      ctrl[CTRL_GATE] = 1'b0;
      if ($urandom_range(0, 1) == 0) ctrl[7:4] = 4'($urandom_range(0, 15));
      send_word(OP_WRITE, REG_CTRL, ctrl);
      run_ticks($urandom_range(1, 30));
   endtask

   task automatic run_phase(input int count, input logic no_idling);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         idle_on <= no_idling ? 1'b0 : ($urandom_range(0, 3) != 0);
         play_note();
      end
   endtask

   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold == 0 && idle_on && $urandom_range(0, 3) == 0) hold = $urandom_range(1, 4);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no word moved on any channel for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset phase scale: every waveform, the test bit,
      // the gate edges and a write to the unused register index.
      send_word(OP_TICK, REG_FREQ_LO, 8'h00);
      send_word(OP_WRITE, REG_FREQ_LO, 8'hFF);
      send_word(OP_WRITE, REG_FREQ_HI, 8'hFF);
      send_word(OP_WRITE, REG_PW_LO, 8'h00);
      send_word(OP_WRITE, REG_PW_HI, 8'hF8);
      send_word(OP_WRITE, REG_AD, 8'h0F);
      send_word(OP_WRITE, REG_SR, 8'hF0);
      send_word(OP_WRITE, REG_CTRL, 8'h11);
      send_word(OP_TICK, REG_SR, 8'hFF);
      send_word(OP_WRITE, REG_CTRL, 8'h21);
      send_word(OP_TICK, REG_NONE, 8'h00);
      send_word(OP_WRITE, REG_CTRL, 8'h41);
      send_word(OP_TICK, REG_CTRL, 8'hAA);
      send_word(OP_WRITE, REG_CTRL, 8'h81);
      send_word(OP_TICK, REG_AD, 8'h55);
      send_word(OP_WRITE, REG_CTRL, 8'hF7);
      send_word(OP_TICK, REG_FREQ_HI, 8'h00);
      send_word(OP_WRITE, REG_CTRL, 8'h19);
      send_word(OP_TICK, REG_PW_LO, 8'h00);
      send_word(OP_WRITE, REG_NONE, 8'hFF);
      send_word(OP_WRITE, REG_CTRL, 8'h10);
      send_word(OP_TICK, REG_PW_HI, 8'h00);
      send_word(OP_WRITE, REG_CTRL, 8'h00);
      send_word(OP_TICK, REG_FREQ_LO, 8'h00);

      set_scale({SCALE_W{1'b1}});
      run_phase(160, 1'b0);
      set_scale(24'd1);
      run_phase(110, 1'b0);
      set_scale(24'($urandom_range(2, 24'hFFFFFE)));
      run_phase(170, 1'b0);
      set_scale(PHASE_SCALE_RST);
      run_phase(150, 1'b0);
      run_phase(110, 1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_due == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/svoe_pkg.sv
rtl/svoe_mul.sv
rtl/synth_voice_oscillator_envelope_unit.sv
rtl/svoe_checker.sv
dv/voice_tick_checker.sv
dv/tb_synth_voice_oscillator_envelope_unit.sv
